// ===== hw/rtl/table_driven_dfa_scanner_defines.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef TABLE_DRIVEN_DFA_SCANNER_DEFINES_SVH
`define TABLE_DRIVEN_DFA_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define TDDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define TDDS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TDDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TDDS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/tdds_pkg.sv =====
// Types, codes and the character classifier of the DFA scanner.
package tdds_pkg;

    localparam int DEF_MAX_STATES = 16;
    localparam int NUM_CLASSES    = 12;
    localparam int CLASS_W        = 4;
    localparam int STATE_W        = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;

    // State code for the error state
    localparam logic [STATE_W-1:0] STATE_ERR = 5'd16;

    // Character classes
    localparam logic [CLASS_W-1:0] CLASS_WS      = 4'd0;
    localparam logic [CLASS_W-1:0] CLASS_NEWLINE = 4'd1;
    localparam logic [CLASS_W-1:0] CLASS_ALPHA   = 4'd2;
    localparam logic [CLASS_W-1:0] CLASS_ZERO    = 4'd3;
    localparam logic [CLASS_W-1:0] CLASS_OCTAL   = 4'd4;
    localparam logic [CLASS_W-1:0] CLASS_DECIMAL = 4'd5;
    localparam logic [CLASS_W-1:0] CLASS_SLASH   = 4'd6;
    localparam logic [CLASS_W-1:0] CLASS_STAR    = 4'd7;
    localparam logic [CLASS_W-1:0] CLASS_ARITH   = 4'd8;
    localparam logic [CLASS_W-1:0] CLASS_OTHER   = 4'd9;
    localparam logic [CLASS_W-1:0] CLASS_EOF     = 4'd10;
    localparam logic [CLASS_W-1:0] CLASS_ERROR   = 4'd11;

    // Character codes used by the classifier
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_EIGHT   = 8'h38;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ASCII_MAX = 8'd127;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 2'd1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_SCAN = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_PROGRESS  = 2'd0,
        ST_ACCEPTED  = 2'd1,
        ST_ABORTED   = 2'd2,
        ST_SKIP_DONE = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t               command;
        logic [3:0]         row_state;
        logic [CLASS_W-1:0] column_class;
        logic [STATE_W-1:0] target_state;
        logic               store_mark;
        logic [7:0]         char_in;
        logic               end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [CLASS_W-1:0] char_class;
        logic [STATE_W-1:0] state_after;
        logic               kept_valid;
        logic [7:0]         kept_char;
        status_t            token_status;
        logic               eof_seen;
    } out_word_t;

    // One transition entry as stored in the table
    typedef struct packed {
        logic [STATE_W-1:0] next;
        logic               store;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Class one byte; the eof mark only wins over other and error bytes
    function automatic logic [CLASS_W-1:0] classify(input logic [7:0] c, input logic eof);
        logic [CLASS_W-1:0] cls;
        if (c == CH_SPACE || c == CH_TAB)
            cls = CLASS_WS;
        else if (c == CH_NEWLINE)
            cls = CLASS_NEWLINE;
        else if (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]})
            cls = CLASS_ALPHA;
        else if (c == CH_ZERO)
            cls = CLASS_ZERO;
        else if (c inside {[CH_ONE:CH_SEVEN]})
            cls = CLASS_OCTAL;
        else if (c inside {CH_EIGHT, CH_NINE})
            cls = CLASS_DECIMAL;
        else if (c == CH_SLASH)
            cls = CLASS_SLASH;
        else if (c == CH_STAR)
            cls = CLASS_STAR;
        else if (c inside {CH_PERCENT, CH_PLUS, CH_MINUS})
            cls = CLASS_ARITH;
        else if (eof)
            cls = CLASS_EOF;
        else if (c > CH_ASCII_MAX)
            cls = CLASS_ERROR;
        else
            cls = CLASS_OTHER;
        return cls;
    endfunction

endpackage

// ===== hw/rtl/tdds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tdds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/table_driven_dfa_scanner.sv =====
// Top level of the table-driven DFA scanner: classifier, transition table and state step.
//
// The scanner takes one word per clock while the output is free, load or scan, and returns one
// result word per input word. The transition table is one small RAM per state row, addressed by
// character class, so a scan reads its whole class column at acceptance; the input stage then
// picks the row of the current state and steps the automaton into the result register. That row
// select and state update is the only loop, so the sustained rate is one word per cycle while
// the output is free. Loaded flags (one flip-flop per entry) are cleared by reset directly; no
// clearing pass is needed, and the block is ready right after reset. Configuration writes are
// always taken and must only be issued while the block is idle.
`include "table_driven_dfa_scanner_defines.svh"

module table_driven_dfa_scanner #(
    parameter int MAX_STATES = tdds_pkg::DEF_MAX_STATES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tdds_pkg::in_word_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output tdds_pkg::out_word_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tdds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdds_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import tdds_pkg::*;

    // Rows beyond sixteen can never be reached through the 4-bit row field
    localparam int ROWS  = (MAX_STATES < 16) ? MAX_STATES : 16;
    localparam int ROW_W = $clog2(ROWS);

    logic [3:0]         start_state_reg;
    logic [3:0]         accept_state_reg;
    logic [STATE_W-1:0] current_state_reg;
    logic [STATE_W-1:0] current_state_next;
    logic               token_open_reg;
    logic               token_open_next;
    logic               skipping_reg;
    logic               skipping_next;
    logic               loaded_reg [ROWS][NUM_CLASSES];

    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic [CLASS_W-1:0] s1_class_reg;
    logic [7:0]         s1_char_reg;
    logic [ROWS-1:0]    s1_loaded_reg;

    logic               out_valid_reg;
    out_word_t          out_reg;
    out_word_t          out_next;

    logic               in_accept;
    logic               s1_move;
    logic               load_ok;
    logic               scan_fire;
    logic [CLASS_W-1:0] in_class;
    entry_t             wr_entry;
    logic [ENTRY_W-1:0] rd_bits [ROWS];

    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] accept_ext;
    logic               in_table;
    logic               hit;
    entry_t             sel_entry;
    logic [STATE_W-1:0] next_state;
    logic               store_hit;

    // Handshakes
    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_move;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Decode the incoming word
    assign in_class  = classify(in_data.char_in, in_data.end_of_input);
    assign scan_fire = in_accept && (in_data.command == CMD_SCAN);
    assign load_ok   = in_accept && (in_data.command == CMD_LOAD)
                       && ({1'b0, in_data.row_state} < STATE_W'(ROWS))
                       && (in_data.column_class < CLASS_W'(NUM_CLASSES));

    // Clamp targets that cannot be a real state to error
    always_comb
    begin
        wr_entry.store = in_data.store_mark;
        if (in_data.target_state >= STATE_W'(ROWS))
            wr_entry.next = STATE_ERR;
        else
            wr_entry.next = in_data.target_state;
    end

    // One table row per state, addressed by class
    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        logic row_we;

        assign row_we = load_ok && ({1'b0, in_data.row_state} == STATE_W'(r));

        tdds_ram #(
            .WIDTH(ENTRY_W),
            .DEPTH(NUM_CLASSES)
        ) u_ram (
            .clk   (clk),
            .we    (row_we),
            .waddr (in_data.column_class),
            .wdata (wr_entry),
            .re    (scan_fire),
            .raddr (in_class),
            .rdata (rd_bits[r])
        );
    end

    // Mark entries as loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    loaded_reg[r][c] <= 1'b0;
                end
            end
        end
        else if (load_ok)
        begin
            loaded_reg[in_data.row_state[ROW_W-1:0]][in_data.column_class] <= 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg  <= 4'd0;
            accept_state_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START:  start_state_reg  <= cfg_data;
                CFG_ACCEPT: accept_state_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    // Input stage payload, with the loaded flags of the class column
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg   <= in_data.command;
            s1_class_reg <= in_class;
            s1_char_reg  <= in_data.char_in;
            for (int r = 0; r < ROWS; r++)
            begin
                s1_loaded_reg[r] <= loaded_reg[r][in_class];
            end
        end
    end

    // Look up the move from the current or start row
    assign accept_ext = {1'b0, accept_state_reg};
    assign from_state = token_open_reg ? current_state_reg : {1'b0, start_state_reg};
    assign in_table   = from_state < STATE_W'(ROWS);
    assign sel_entry  = entry_t'(rd_bits[from_state[ROW_W-1:0]]);
    assign hit        = in_table && s1_loaded_reg[from_state[ROW_W-1:0]];
    assign store_hit  = hit && sel_entry.store;

    always_comb
    begin
        if (hit)
            next_state = sel_entry.next;
        else if (s1_class_reg == CLASS_EOF && from_state != accept_ext)
            next_state = accept_ext;
        else
            next_state = STATE_ERR;
    end

    // Step the token state and build the result word
    always_comb
    begin
        current_state_next = current_state_reg;
        token_open_next    = token_open_reg;
        skipping_next      = skipping_reg;
        out_next           = '0;
        if (s1_cmd_reg == CMD_SCAN)
        begin
            current_state_next    = next_state;
            out_next.char_class   = s1_class_reg;
            out_next.state_after  = next_state;
            out_next.eof_seen     = (s1_class_reg == CLASS_EOF);
            if (!skipping_reg)
            begin
                if (next_state != STATE_ERR && store_hit)
                begin
                    out_next.kept_valid = 1'b1;
                    out_next.kept_char  = s1_char_reg;
                end
                if (next_state == accept_ext)
                begin
                    out_next.token_status = ST_ACCEPTED;
                    token_open_next       = 1'b0;
                end
                else if (next_state == STATE_ERR)
                begin
                    out_next.token_status = ST_ABORTED;
                    token_open_next       = 1'b0;
                    skipping_next         = 1'b1;
                end
                else
                begin
                    token_open_next = 1'b1;
                end
            end
            else
            begin
                if (next_state == accept_ext)
                begin
                    out_next.token_status = ST_SKIP_DONE;
                    token_open_next       = 1'b0;
                    skipping_next         = 1'b0;
                end
                else if (next_state == STATE_ERR)
                begin
                    token_open_next = 1'b0;
                end
                else
                begin
                    token_open_next = 1'b1;
                end
            end
        end
    end

    // Commit the step when the word advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_state_reg <= '0;
            token_open_reg    <= 1'b0;
            skipping_reg      <= 1'b0;
        end
        else if (s1_move)
        begin
            current_state_reg <= current_state_next;
            token_open_reg    <= token_open_next;
            skipping_reg      <= skipping_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    `TDDS_ASSERT_NXT(a_skip_no_keep, clk, rst_n, s1_move && s1_cmd_reg == CMD_SCAN && skipping_reg, !out_reg.kept_valid, "character kept while skipping")
    `TDDS_ASSERT_NXT(a_load_zero, clk, rst_n, s1_move && s1_cmd_reg == CMD_LOAD, out_reg == '0, "load result not zero")
    `TDDS_ASSERT_NXT(a_abort_skip, clk, rst_n, s1_move && s1_cmd_reg == CMD_SCAN && out_next.token_status == ST_ABORTED, skipping_reg, "abort did not start skipping")
    `TDDS_ASSERT_IMP(a_open_not_err, clk, rst_n, token_open_reg, current_state_reg != STATE_ERR, "token open in error state")
    `TDDS_ASSERT_IMP(a_kept_char_zero, clk, rst_n, out_valid_reg && !out_reg.kept_valid, out_reg.kept_char == '0, "kept_char set without kept_valid")

endmodule
